@@ hw/rtl/hrfp_pkg.sv @@
package hrfp_pkg;

  localparam int MAX_DATA = 32;
  localparam int ADDR_W   = $clog2(MAX_DATA);

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_COLON = 2'd1;
  localparam logic [1:0] FAULT_COUNT = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       file_end;
  } in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
    logic [1:0] fault;
  } out_t;

  // Port bundle of the record data buffer.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

endpackage

@@ hw/rtl/hex_record_to_frame_parser_unit.sv @@
// Flow: a newline that ends a record and has results to send, or a character where a colon
// was due, stalls the input while its results go out; each result byte passes a buffer read
// state, then an output load state that waits while the output is stalled.
// Throughput: one character a cycle within a record; a data frame for n data bytes is 6+n bytes.
// Reset: synchronous, active low; clears the parser and output control. The data buffer is
// not cleared and holds whatever was last written to it.
module hex_record_to_frame_parser_unit
  import hrfp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam logic [1:0] PH_COLON  = 2'd0;
  localparam logic [1:0] PH_RECORD = 2'd1;
  localparam logic [1:0] PH_ERROR  = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  localparam logic [1:0] EM_FRAME = 2'd0;
  localparam logic [1:0] EM_EOF   = 2'd1;
  localparam logic [1:0] EM_COLON = 2'd2;
  localparam logic [1:0] EM_COUNT = 2'd3;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] TYPE_EXT   = 8'h04;
  localparam logic [7:0] TAG_LEAD   = 8'h00;
  localparam logic [7:0] TAG_DATA   = 8'h01;
  localparam logic [7:0] TAG_EOF    = 8'h03;
  localparam logic [5:0] DATA_OFS   = 6'd4;
  localparam logic [5:0] HDR_LEN    = 6'd6;
  localparam logic [5:0] POS_MAX    = 6'd63;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] d;
    lc = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      lc = c + 8'h20;
    end
    d = lc - 8'h30;
    if (!d[7] && d > 8'd9) begin
      d = d - 8'd7;
    end
    return d[3:0];
  endfunction

  logic [1:0] phase_r, phase_nxt;
  logic       second_r, second_nxt;
  logic [3:0] high_r, high_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] offh_r, offh_nxt;
  logic [7:0] offl_r, offl_nxt;
  logic [7:0] exth_r, exth_nxt;
  logic [7:0] extl_r, extl_nxt;
  logic       extrec_r, extrec_nxt;

  logic [1:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [5:0] last_r, last_nxt;

  logic       out_valid_r, out_valid_nxt;
  out_t       out_r, out_nxt;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  logic       in_acc;
  logic       slot_free;
  logic [7:0] pair_byte;
  logic [5:0] data_idx;
  logic [5:0] rd_off;
  logic [7:0] emit_byte;

  hrfp_data_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign pair_byte = {high_r, nibble_of(in_data.char_in)};
  assign data_idx  = pos_r - DATA_OFS;
  assign rd_off    = idx_r - HDR_LEN;

  // Buffer writes happen only while idle and reads only while emitting, so the two never
  // meet on one entry at the same time.
  always_comb begin
    phase_nxt  = phase_r;
    second_nxt = second_r;
    high_nxt   = high_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    offh_nxt   = offh_r;
    offl_nxt   = offl_r;
    exth_nxt   = exth_r;
    extl_nxt   = extl_r;
    extrec_nxt = extrec_r;
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    ram_req.wr_en   = 1'b0;
    ram_req.wr_addr = data_idx[ADDR_W-1:0];
    ram_req.wr_data = pair_byte;
    ram_req.rd_en   = 1'b0;
    ram_req.rd_addr = rd_off[ADDR_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (phase_r)
            PH_COLON: begin
              if (in_data.char_in == CH_COLON) begin
                phase_nxt  = PH_RECORD;
                pos_nxt    = 6'd0;
                second_nxt = 1'b0;
              end else begin
                phase_nxt = PH_ERROR;
                mode_nxt  = EM_COLON;
                idx_nxt   = 6'd0;
                last_nxt  = 6'd0;
                state_nxt = ST_RD;
              end
            end
            PH_RECORD: begin
              if (in_data.char_in == CH_NEWLINE) begin
                second_nxt = 1'b0;
                phase_nxt  = PH_COLON;
                idx_nxt    = 6'd0;
                if (in_data.file_end) begin
                  extrec_nxt = 1'b0;
                  mode_nxt   = EM_EOF;
                  last_nxt   = 6'd1;
                  state_nxt  = ST_RD;
                end else if (!extrec_r) begin
                  if (count_r > 8'(MAX_DATA)) begin
                    mode_nxt = EM_COUNT;
                    last_nxt = 6'd0;
                  end else begin
                    mode_nxt = EM_FRAME;
                    last_nxt = 6'd5 + count_r[5:0];
                  end
                  state_nxt = ST_RD;
                end
              end else if (!second_r) begin
                high_nxt   = nibble_of(in_data.char_in);
                second_nxt = 1'b1;
              end else begin
                second_nxt = 1'b0;
                case (pos_r)
                  6'd0: count_nxt = pair_byte;
                  6'd1: offh_nxt  = pair_byte;
                  6'd2: offl_nxt  = pair_byte;
                  6'd3: extrec_nxt = (pair_byte == TYPE_EXT);
                  default: begin
                    if (pos_r == 6'd4 && extrec_r) begin
                      exth_nxt = pair_byte;
                    end else if (pos_r == 6'd5 && extrec_r) begin
                      extl_nxt = pair_byte;
                    end else if (data_idx < 6'(MAX_DATA)) begin
                      ram_req.wr_en = 1'b1;
                    end
                  end
                endcase
                if (pos_r != POS_MAX) begin
                  pos_nxt = pos_r + 6'd1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        ram_req.rd_en = 1'b1;
        state_nxt     = ST_WR;
      end
      ST_WR: begin
        if (slot_free) begin
          idx_nxt   = idx_r + 6'd1;
          state_nxt = (idx_r == last_r) ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_byte = TAG_LEAD;
    case (mode_r)
      EM_FRAME: begin
        case (idx_r)
          6'd0: emit_byte = TAG_LEAD;
          6'd1: emit_byte = TAG_DATA;
          6'd2: emit_byte = exth_r;
          6'd3: emit_byte = extl_r;
          6'd4: emit_byte = offh_r;
          6'd5: emit_byte = offl_r;
          default: emit_byte = ram_rdata;
        endcase
      end
      EM_EOF: emit_byte = (idx_r == 6'd0) ? TAG_LEAD : TAG_EOF;
      default: emit_byte = TAG_LEAD;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (state_r == ST_WR && slot_free) begin
      out_valid_nxt      = 1'b1;
      out_nxt.frame_byte = emit_byte;
      out_nxt.frame_last = (idx_r == last_r);
      case (mode_r)
        EM_COLON: out_nxt.fault = FAULT_COLON;
        EM_COUNT: out_nxt.fault = FAULT_COUNT;
        default:  out_nxt.fault = FAULT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_COLON;
      second_r    <= 1'b0;
      high_r      <= 4'd0;
      pos_r       <= 6'd0;
      count_r     <= 8'd0;
      offh_r      <= 8'd0;
      offl_r      <= 8'd0;
      exth_r      <= 8'd0;
      extl_r      <= 8'd0;
      extrec_r    <= 1'b0;
      state_r     <= ST_IDLE;
      mode_r      <= EM_FRAME;
      idx_r       <= 6'd0;
      last_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      second_r    <= second_nxt;
      high_r      <= high_nxt;
      pos_r       <= pos_nxt;
      count_r     <= count_nxt;
      offh_r      <= offh_nxt;
      offl_r      <= offl_nxt;
      exth_r      <= exth_nxt;
      extl_r      <= extl_nxt;
      extrec_r    <= extrec_nxt;
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      idx_r       <= idx_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("error phase left without reset");

  a_fault_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.fault != FAULT_NONE |-> out_r.frame_last && out_r.frame_byte == 8'd0)
    else $error("fault transfer not a lone zero byte");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> idx_r <= last_r)
    else $error("emit index ran past the last byte");

  a_no_write_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !ram_req.wr_en)
    else $error("buffer written while a frame is going out");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == POS_MAX |=> pos_r == POS_MAX || pos_r == 6'd0)
    else $error("byte position wrapped");

endmodule

@@ hw/rtl/hrfp_data_ram.sv @@
module hrfp_data_ram
  import hrfp_pkg::*;
(
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [MAX_DATA];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ bench/tb_hex_record_to_frame_parser_unit.sv @@
`timescale 1ns / 100ps

module tb_hex_record_to_frame_parser_unit;
  import hrfp_pkg::*;

  typedef enum logic [1:0] {
    PARSE_COLON,
    PARSE_RECORD,
    PARSE_ERROR
  } parse_phase_e;

  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] REC_DATA      = 8'h00;
  localparam logic [7:0] REC_EOF       = 8'h01;
  localparam logic [7:0] REC_EXT_ADDR  = 8'h04;
  localparam logic [7:0] FRAME_LEAD    = 8'h00;
  localparam logic [7:0] FRAME_DATA    = 8'h01;
  localparam logic [7:0] FRAME_EOF     = 8'h03;
  localparam int         POS_SATURATE  = 63;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Copy of the parser state, advanced as each character is handed over.
  parse_phase_e ph;
  bit           pair_second;
  logic [3:0]   pair_high;
  logic [5:0]   pos;
  logic [7:0]   rec_count;
  logic [7:0]   off_hi;
  logic [7:0]   off_lo;
  logic [7:0]   ext_hi;
  logic [7:0]   ext_lo;
  bit           ext_rec;
  logic [7:0]   store [MAX_DATA];
  bit           written [MAX_DATA];

  out_t frame_bytes_due [$];
  out_t oldest_due;
  int   mismatches = 0;
  int   chars_sent = 0;
  bit   calm       = 1'b0;

  hex_record_to_frame_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_hex_record_to_frame_parser_unit: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] d;
    lc = c;
    if (lc >= 8'h41 && lc <= 8'h5A) begin
      lc = lc + 8'h20;
    end
    d = lc - 8'h30;
    // Characters below '0' wrap to a large value and are not adjusted.
    if (d < 8'h80 && d > 8'd9) begin
      d = d - 8'd7;
    end
    return d[3:0];
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return 8'h30 + {4'h0, n};
    end else if (lower) begin
      return 8'h61 + {4'h0, n} - 8'd10;
    end else begin
      return 8'h41 + {4'h0, n} - 8'd10;
    end
  endfunction

  task automatic queue_frame_byte(input logic [7:0] b, input logic last,
                                  input logic [1:0] flt);
    out_t e;
    e.frame_byte = b;
    e.frame_last = last;
    e.fault      = flt;
    frame_bytes_due.push_back(e);
  endtask

  task automatic clear_parser_copy();
    ph          = PARSE_COLON;
    pair_second = 1'b0;
    pair_high   = '0;
    pos         = '0;
    rec_count   = '0;
    off_hi      = '0;
    off_lo      = '0;
    ext_hi      = '0;
    ext_lo      = '0;
    ext_rec     = 1'b0;
    for (int i = 0; i < MAX_DATA; i++) begin
      store[i]   = '0;
      written[i] = 1'b0;
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    int p;
    p = pos;
    case (p)
      0: rec_count = b;
      1: off_hi = b;
      2: off_lo = b;
      3: ext_rec = (b == REC_EXT_ADDR);
      default: begin
        if ((p == 4 || p == 5) && ext_rec) begin
          if (p == 4) ext_hi = b;
          else ext_lo = b;
        end else if (p - 4 < MAX_DATA) begin
          store[p - 4]   = b;
          written[p - 4] = 1'b1;
        end
      end
    endcase
    if (p < POS_SATURATE) begin
      pos = pos + 6'd1;
    end
  endtask

  task automatic predict_frame_bytes(input logic [7:0] c, input logic fe);
    if (ph == PARSE_COLON) begin
      if (c == CH_COLON) begin
        ph          = PARSE_RECORD;
        pos         = '0;
        pair_second = 1'b0;
      end else begin
        ph = PARSE_ERROR;
        queue_frame_byte(8'h00, 1'b1, FAULT_COLON);
      end
    end else if (ph == PARSE_RECORD) begin
      if (c == CH_NEWLINE) begin
        pair_second = 1'b0;
        ph          = PARSE_COLON;
        if (fe) begin
          ext_rec = 1'b0;
          queue_frame_byte(FRAME_LEAD, 1'b0, FAULT_NONE);
          queue_frame_byte(FRAME_EOF, 1'b1, FAULT_NONE);
        end else if (!ext_rec) begin
          if (rec_count > MAX_DATA) begin
            queue_frame_byte(8'h00, 1'b1, FAULT_COUNT);
          end else begin
            queue_frame_byte(FRAME_LEAD, 1'b0, FAULT_NONE);
            queue_frame_byte(FRAME_DATA, 1'b0, FAULT_NONE);
            queue_frame_byte(ext_hi, 1'b0, FAULT_NONE);
            queue_frame_byte(ext_lo, 1'b0, FAULT_NONE);
            queue_frame_byte(off_hi, 1'b0, FAULT_NONE);
            queue_frame_byte(off_lo, rec_count == 8'd0, FAULT_NONE);
            for (int i = 0; i < rec_count; i++) begin
              queue_frame_byte(store[i], (i + 1) == rec_count, FAULT_NONE);
            end
          end
        end
      end else if (!pair_second) begin
        pair_high   = digit_value(c);
        pair_second = 1'b1;
      end else begin
        pair_second = 1'b0;
        absorb_byte({pair_high, digit_value(c)});
      end
    end
  endtask

  // True when a plain newline now would send buffer entries not yet written.
  function automatic bit would_read_blank();
    if (ph != PARSE_RECORD || ext_rec || rec_count > MAX_DATA) begin
      return 1'b0;
    end
    for (int i = 0; i < rec_count; i++) begin
      if (!written[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fe);
    in_t item;
    item.char_in  = c;
    item.file_end = fe;
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    predict_frame_bytes(c, fe);
    chars_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_newline(input logic fe);
    // Marking the end of the image keeps unwritten buffer entries out of a frame.
    if (!fe && would_read_blank()) begin
      fe = 1'b1;
    end
    send_char(CH_NEWLINE, fe);
  endtask

  task automatic send_hex_byte(input logic [7:0] b);
    send_char(hex_digit(b[7:4], 1'($urandom_range(1))), $urandom_range(9) == 0);
    send_char(hex_digit(b[3:0], 1'($urandom_range(1))), $urandom_range(9) == 0);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == CH_NEWLINE) send_newline(1'b0);
      else send_char(s[i], 1'b0);
    end
  endtask

  task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                             input logic [7:0] rtype, input int n_data, input logic fe);
    send_char(CH_COLON, $urandom_range(9) == 0);
    send_hex_byte(count);
    send_hex_byte(addr[15:8]);
    send_hex_byte(addr[7:0]);
    send_hex_byte(rtype);
    repeat (n_data) send_hex_byte(8'($urandom_range(255)));
    send_hex_byte(8'($urandom_range(255)));
    send_newline(fe);
  endtask

  task automatic send_random_record();
    int          kind;
    int          r;
    int          n;
    logic [7:0]  count;
    logic [7:0]  rtype;
    logic [7:0]  c;
    kind = $urandom_range(99);
    if (kind < 75) begin
      r = $urandom_range(99);
      if (r < 60) rtype = REC_DATA;
      else if (r < 75) rtype = REC_EXT_ADDR;
      else if (r < 85) rtype = REC_EOF;
      else rtype = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (rtype == REC_EXT_ADDR) count = 8'd2;
      else if (r < 70) count = 8'($urandom_range(8));
      else if (r < 92) count = 8'($urandom_range(MAX_DATA, 9));
      else count = 8'($urandom_range(255, MAX_DATA + 1));
      if (count > MAX_DATA) n = $urandom_range(MAX_DATA + 8);
      else if ($urandom_range(99) < 85) n = count;
      else n = $urandom_range(count + 3);
      send_record(count, 16'($urandom_range(16'hFFFF)), rtype, n, $urandom_range(19) == 0);
    end else begin
      // Malformed record: odd digit counts, stray characters, early newlines.
      send_char(CH_COLON, 1'($urandom_range(1)));
      n = $urandom_range(14);
      repeat (n) begin
        if ($urandom_range(1)) begin
          c = hex_digit(4'($urandom_range(15)), 1'($urandom_range(1)));
        end else begin
          c = 8'($urandom_range(255));
          if (c == CH_NEWLINE) c = 8'h0B;
        end
        send_char(c, $urandom_range(9) == 0);
      end
      send_newline($urandom_range(9) == 0);
    end
  endtask

  task automatic test_empty_record();
    send_record(8'h00, 16'h0000, REC_DATA, 0, 1'b0);
    send_record(8'h00, 16'hFFFF, REC_DATA, 0, 1'b0);
  endtask

  task automatic test_full_buffer();
    send_record(8'(MAX_DATA), 16'hFFFF, REC_DATA, MAX_DATA, 1'b0);
    send_record(8'h01, 16'h0000, REC_DATA, 1, 1'b0);
  endtask

  task automatic test_extended_address();
    send_text(":02000004FFFFFC\n");
    send_record(8'h01, 16'($urandom_range(16'hFFFF)), REC_DATA, 1, 1'b0);
    send_text(":020000040000FA\n");
    send_record(8'h01, 16'($urandom_range(16'hFFFF)), REC_DATA, 1, 1'b0);
  endtask

  task automatic test_count_limits();
    send_record(8'(MAX_DATA + 1), 16'($urandom_range(16'hFFFF)), REC_DATA, 0, 1'b0);
    send_record(8'hFF, 16'($urandom_range(16'hFFFF)), REC_DATA, 0, 1'b0);
  endtask

  task automatic test_data_past_buffer();
    // Long enough for the byte position to saturate.
    send_record(8'h05, 16'($urandom_range(16'hFFFF)), REC_DATA, 60, 1'b0);
  endtask

  task automatic test_half_pair();
    send_text(":03123400a1b2c3d\n");
    send_text(":A\n");
  endtask

  task automatic test_short_record();
    send_text(":020000043456C4\n");
    send_text(":0512\n");
    send_text(":03ABCD00010203\n");
    send_text(":02FE\n");
  endtask

  task automatic test_end_of_image();
    send_record(8'h00, 16'h0000, REC_EOF, 0, 1'b1);
    send_record(8'h01, 16'($urandom_range(16'hFFFF)), REC_DATA, 1, 1'b1);
    send_record(8'h02, 16'h0000, REC_EXT_ADDR, 2, 1'b1);
    send_text(":\n");
    send_record(8'h00, 16'h0000, REC_EOF, 0, 1'b0);
  endtask

  task automatic test_odd_characters();
    send_char(CH_COLON, 1'b1);
    send_text("02Ab");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b0);
    send_text(":gZz");
    send_char(8'h80, 1'b0);
    send_char(8'h2F, 1'b0);
    send_newline(1'b0);
  endtask

  task automatic test_random_records();
    int start;
    start = chars_sent;
    while (chars_sent - start < 30) send_random_record();
  endtask

  task automatic test_back_to_back();
    int start;
    calm  = 1'b1;
    start = chars_sent;
    while (chars_sent - start < 20) send_random_record();
    calm  = 1'b0;
  endtask

  task automatic test_missing_colon();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == CH_COLON) c = CH_NEWLINE;
    send_char(c, 1'b0);
    // The error is sticky, so none of these may produce anything.
    send_char(CH_COLON, 1'b0);
    send_char(8'h30, 1'b1);
    send_char(CH_NEWLINE, 1'b1);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_due.size() == 0) begin
        report_mismatch($sformatf("transfer %02h/%0b/%0d with nothing due",
                                  out_data.frame_byte, out_data.frame_last, out_data.fault));
      end else begin
        oldest_due = frame_bytes_due.pop_front();
        if (out_data.frame_byte !== oldest_due.frame_byte)
          report_mismatch($sformatf("frame_byte %02h, wanted %02h",
                                    out_data.frame_byte, oldest_due.frame_byte));
        if (out_data.frame_last !== oldest_due.frame_last)
          report_mismatch($sformatf("frame_last %0b, wanted %0b",
                                    out_data.frame_last, oldest_due.frame_last));
        if (out_data.fault !== oldest_due.fault)
          report_mismatch($sformatf("fault %0d, wanted %0d",
                                    out_data.fault, oldest_due.fault));
      end
    end
  end

  initial begin
    clear_parser_copy();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_record();
    test_full_buffer();
    test_extended_address();
    test_count_limits();
    test_data_past_buffer();
    test_half_pair();
    test_short_record();
    test_end_of_image();
    test_odd_characters();
    test_random_records();
    test_back_to_back();
    test_missing_colon();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_hex_record_to_frame_parser_unit: clean");
    end else begin
      $display("tb_hex_record_to_frame_parser_unit: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hrfp_pkg.sv
hw/rtl/hrfp_data_ram.sv
hw/rtl/hex_record_to_frame_parser_unit.sv
bench/tb_hex_record_to_frame_parser_unit.sv
